### hw/rtl/gds_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the shade lookup of the gray Sobel shader.
package gds_pkg;

  localparam int HEIGHT_LIMIT  = 256;
  localparam int SIZE_FLOOR    = 6;
  localparam int SIZE_RESET    = 32;
  localparam int LEVEL_SHIFT   = 6;
  localparam int SHADE_ENTRIES = 16;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // ASCII codes
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_AT    = 7'h40;
  localparam logic [6:0] CHAR_UNDER = 7'h5F;

  typedef logic [7:0] gray_t;

  // one column of the window, top to bottom
  typedef struct packed {
    gray_t top;
    gray_t mid;
    gray_t bot;
  } gcol_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    gcol_t left;
    gcol_t centre;
    gcol_t right;
  } win_t;

  typedef struct packed {
    logic       last;
    logic [4:0] level;
    logic [6:0] shade;
  } shade_t;

  typedef struct packed {
    logic   valid;
    shade_t data;
  } res_t;

  function automatic logic [6:0] shade_of(input logic [4:0] level);
    logic [6:0] code;
    unique case (level)
      5'd2:    code = 7'h2E; // '.'
      5'd3:    code = 7'h2D; // '-'
      5'd4:    code = 7'h3A; // ':'
      5'd5:    code = 7'h30; // '0'
      5'd6:    code = 7'h2B; // '+'
      5'd7:    code = 7'h30; // '0'
      5'd8:    code = 7'h78; // 'x'
      5'd9:    code = 7'h79; // 'y'
      5'd10:   code = 7'h6F; // 'o'
      5'd11:   code = 7'h41; // 'A'
      5'd12:   code = 7'h23; // '#'
      5'd13:   code = 7'h24; // '$'
      5'd14:   code = 7'h25; // '%'
      5'd15:   code = CHAR_AT;
      5'd16:   code = CHAR_UNDER;
      default: code = CHAR_SPACE;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/gds_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module gds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/gds_sobel.sv
`timescale 1ns / 1ps
// Two-stage Sobel L1 magnitude with shade lookup.
module gds_sobel import gds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  win_t win_i,
  output res_t res_o
);

  logic [9:0]         lsum, rsum, tsum, bsum;
  logic signed [10:0] gx_nxt, gy_nxt;
  logic signed [10:0] gx_r, gy_r;
  logic               v_r, last_r;
  logic [10:0]        ax, ay, mag;
  logic [4:0]         level;
  res_t               res_r;

  // column and row weighted sums
  always_comb begin
    lsum = 10'(win_i.left.top) + {1'b0, win_i.left.mid, 1'b0} + 10'(win_i.left.bot);
    rsum = 10'(win_i.right.top) + {1'b0, win_i.right.mid, 1'b0} + 10'(win_i.right.bot);
    tsum = 10'(win_i.left.top) + {1'b0, win_i.centre.top, 1'b0} + 10'(win_i.right.top);
    bsum = 10'(win_i.left.bot) + {1'b0, win_i.centre.bot, 1'b0} + 10'(win_i.right.bot);
    gx_nxt = $signed({1'b0, lsum}) - $signed({1'b0, rsum});
    gy_nxt = $signed({1'b0, tsum}) - $signed({1'b0, bsum});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= win_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    last_r <= win_i.last;
  end

  always_comb begin
    ax    = gx_r[10] ? 11'(-gx_r) : 11'(gx_r);
    ay    = gy_r[10] ? 11'(-gy_r) : 11'(gy_r);
    mag   = ax + ay;
    level = 5'(mag >> LEVEL_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r.data.last  <= last_r;
    res_r.data.level <= level;
    res_r.data.shade <= shade_of(level);
  end

  assign res_o = res_r;

endmodule

### hw/rtl/gray_downsample_sobel_ascii.sv
`timescale 1ns / 1ps
// Top level of the RGB-to-gray downsampler with Sobel edge shading.
//
// Takes one RGB pixel per clock in raster order, averages every 2x2 block into
// one gray pixel and runs a 3x3 Sobel window over the half-size gray image.
// Each full window position yields one request on the out_ channel: the L1
// edge magnitude shifted right by six, its ASCII shade and a flag on the last
// result of the frame. A pixel is accepted every cycle while in_ready is high;
// a result passes the stage B, window, Sobel and shade registers, then a
// four-entry queue; in_ready drops while four results owed to accepted
// pixels are not yet taken, so a slow sink throttles the input once four are
// outstanding. Two line memories hold the state across rows: one keeps the
// horizontal pair sums of the upper row of each 2x2 block, the other the two
// previous gray rows per gray column; each is read once per lower-row pixel
// pair through its single read port. No clearing pass is needed after reset.
// Frame width and height are written through cfg_ (index 0 and 1) while the
// block is idle; odd values drop their low bit and sizes clamp to 6..MAX_WIDTH
// and 6..256.
module gray_downsample_sobel_ascii import gds_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_edge_level,
  output logic [6:0] out_shade_code,
  output logic       out_last_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int W_TOP      = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int W_RESET    = (W_TOP < SIZE_RESET) ? W_TOP : SIZE_RESET;

  // ---------------------------------------------------------------------------
  // Configuration: store the clamped last column and last row directly.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_last_r, col_last_nxt;
  logic [7:0]       row_last_r, row_last_nxt;
  logic [8:0]       cfg_even;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_even = {cfg_data[8:1], 1'b0};
    if (int'(cfg_even) < SIZE_FLOOR) begin
      col_last_nxt = COL_W'(SIZE_FLOOR - 1);
      row_last_nxt = 8'(SIZE_FLOOR - 1);
    end else begin
      col_last_nxt = (int'(cfg_even) > W_TOP) ? COL_W'(W_TOP - 1)
                                              : COL_W'(int'(cfg_even) - 1);
      row_last_nxt = (int'(cfg_even) > HEIGHT_LIMIT) ? 8'(HEIGHT_LIMIT - 1)
                                                     : 8'(int'(cfg_even) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= COL_W'(W_RESET - 1);
      row_last_r <= 8'(SIZE_RESET - 1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  col_last_r <= col_last_nxt;
        CFG_FRAME_HEIGHT: row_last_r <= row_last_nxt;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input position and pixel pairing (stage A, the accept cycle).
  // ---------------------------------------------------------------------------
  logic             acc;
  logic [COL_W-1:0] col_r;
  logic [7:0]       row_r;
  logic             end_col, end_row;
  logic [ADDR_W-1:0] gc;
  logic             pair_done, upper_row, emit_a, last_a;
  logic [23:0]      pend_r;
  logic [8:0]       sr, sg, sb;
  logic [CNT_W-1:0] cred_r;

  assign acc       = in_valid && in_ready;
  assign end_col   = col_r >= col_last_r;
  assign end_row   = row_r >= row_last_r;
  assign gc        = col_r[ADDR_W:1];
  assign pair_done = col_r[0];
  assign upper_row = !row_r[0];
  // a window fits once two gray columns and two gray rows lie before this one
  assign emit_a    = pair_done && !upper_row && (|col_r[COL_W-1:2]) && (|row_r[7:2]);
  assign last_a    = end_col && end_row;

  assign sr = 9'(in_red)   + 9'(pend_r[23:16]);
  assign sg = 9'(in_green) + 9'(pend_r[15:8]);
  assign sb = 9'(in_blue)  + 9'(pend_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (end_col) begin
        col_r <= '0;
        row_r <= end_row ? 8'd0 : row_r + 8'd1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // hold the left pixel of each horizontal pair
  always_ff @(posedge clk) begin
    if (acc && !pair_done) begin
      pend_r <= {in_red, in_green, in_blue};
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories. An entry is touched once per gray row and the width is at
  // least three gray columns, so a read never meets a pending write to the
  // same entry and no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [26:0] pair_rd;
  logic [15:0] gray_rd;
  logic        line_rd;

  assign line_rd = acc && pair_done && !upper_row;

  // upper row of a block writes its pair sums; the lower row reads them back
  gds_ram #(
    .WIDTH(27),
    .DEPTH(LINE_DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (acc && pair_done && upper_row),
    .wr_addr (gc),
    .wr_data ({sr, sg, sb}),
    .rd_en   (line_rd),
    .rd_addr (gc),
    .rd_data (pair_rd)
  );

  // stage A -> B
  logic              s1_v_r, s1_emit_r, s1_last_r;
  logic [ADDR_W-1:0] s1_gc_r;
  logic [8:0]        s1_sr_r, s1_sg_r, s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= line_rd;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r <= emit_a;
    s1_last_r <= last_a;
    s1_gc_r   <= gc;
    s1_sr_r   <= sr;
    s1_sg_r   <= sg;
    s1_sb_r   <= sb;
  end

  // ---------------------------------------------------------------------------
  // Stage B: finish the 2x2 sums, form the gray pixel, update the gray lines
  // and shift the window.
  // ---------------------------------------------------------------------------
  logic [9:0]  tr, tg, tb;
  logic [12:0] r5;
  logic [13:0] g9;
  logic [10:0] gsum;
  gray_t       gray;
  gcol_t       cur;

  always_comb begin
    tr   = 10'(s1_sr_r) + 10'(pair_rd[26:18]);
    tg   = 10'(s1_sg_r) + 10'(pair_rd[17:9]);
    tb   = 10'(s1_sb_r) + 10'(pair_rd[8:0]);
    r5   = (13'(tr) << 2) + 13'(tr);
    g9   = (14'(tg) << 3) + 14'(tg);
    gsum = 11'(r5 >> 4) + 11'(g9 >> 4) + 11'(tb >> 3);
    gray = 8'(gsum >> 2);
    cur  = {gray_rd[15:8], gray_rd[7:0], gray};
  end

  // older gray row in the high byte; advance both rows on write-back
  gds_ram #(
    .WIDTH(16),
    .DEPTH(LINE_DEPTH)
  ) u_gray_ram (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_gc_r),
    .wr_data ({gray_rd[7:0], gray}),
    .rd_en   (line_rd),
    .rd_addr (gc),
    .rd_data (gray_rd)
  );

  gcol_t left_r, centre_r;
  win_t  win_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      left_r   <= centre_r;
      centre_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.valid <= 1'b0;
    end else begin
      win_r.valid <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    win_r.last   <= s1_last_r;
    win_r.left   <= left_r;
    win_r.centre <= centre_r;
    win_r.right  <= cur;
  end

  // ---------------------------------------------------------------------------
  // Stages C and D: Sobel magnitude and shade.
  // ---------------------------------------------------------------------------
  res_t res;

  gds_sobel u_sobel (
    .clk   (clk),
    .rst_n (rst_n),
    .win_i (win_r),
    .res_o (res)
  );

  // ---------------------------------------------------------------------------
  // Result queue. cred_r counts results promised by accepted pixels and not
  // yet taken; it never exceeds the queue depth, so the queue cannot overflow.
  // ---------------------------------------------------------------------------
  shade_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic             push, pop, cred_inc;

  assign push     = res.valid;
  assign pop      = out_valid && out_ready;
  assign cred_inc = acc && emit_a;
  assign in_ready = cred_r != CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      cred_r     <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + 1'b1;
        2'b01:   fifo_cnt_r <= fifo_cnt_r - 1'b1;
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
      case ({cred_inc, pop})
        2'b10:   cred_r <= cred_r + 1'b1;
        2'b01:   cred_r <= cred_r - 1'b1;
        default: cred_r <= cred_r;
      endcase
    end
  end

  assign out_valid         = fifo_cnt_r != '0;
  assign out_edge_level    = fifo_r[rd_ptr_r].level;
  assign out_shade_code    = fifo_r[rd_ptr_r].shade;
  assign out_last_of_frame = fifo_r[rd_ptr_r].last;

endmodule

### hw/rtl/gds_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the gray Sobel shader and their bind to the top level.
module gds_checker import gds_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_edge_level,
  input logic [6:0] out_shade_code,
  input logic       out_last_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_level) &&
      $stable(out_shade_code) && $stable(out_last_of_frame))
    else $error("stalled result request changed");

  a_blank_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_level == 5'd0 || out_edge_level > 5'(SHADE_ENTRIES))
      |-> out_shade_code == CHAR_SPACE)
    else $error("level outside the shade range gave a visible character");

  a_top_shades: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_level == 5'(SHADE_ENTRIES) || out_edge_level == 5'd15)
      |-> out_shade_code == ((out_edge_level == 5'(SHADE_ENTRIES)) ? CHAR_UNDER : CHAR_AT))
    else $error("strongest edge levels gave the wrong shade");

endmodule

bind gray_downsample_sobel_ascii gds_checker u_gds_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_edge_level    (out_edge_level),
  .out_shade_code    (out_shade_code),
  .out_last_of_frame (out_last_of_frame)
);

### test/sobel_shade_checker.sv
`timescale 1ns / 1ps
// Checker for the gray downsampler with Sobel shading: predicts and compares each result.
module sobel_shade_checker import gds_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [4:0] out_edge_level,
  input  logic [6:0] out_shade_code,
  input  logic       out_last_of_frame,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  output int         mismatches,
  output int         pending
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [7:0]  col;
  logic [7:0]  row;
  logic [23:0] held_px;
  logic [26:0] pair_mem [LINE_DEPTH];
  logic [15:0] gray_mem [LINE_DEPTH];
  logic [47:0] win;
  shade_t      shade_q [$];
  int          errors = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int fit_size(input logic [8:0] raw, input int limit);
    int v;
    v = int'(raw) & ~1;
    if (v < SIZE_FLOOR) v = SIZE_FLOOR;
    if (v > limit) v = limit;
    return v;
  endfunction

  function automatic logic [6:0] ascii_for(input int lvl);
    logic [7:0] ch;
    case (lvl)
      2:       ch = ".";
      3:       ch = "-";
      4:       ch = ":";
      5:       ch = "0";
      6:       ch = "+";
      7:       ch = "0";
      8:       ch = "x";
      9:       ch = "y";
      10:      ch = "o";
      11:      ch = "A";
      12:      ch = "#";
      13:      ch = "$";
      14:      ch = "%";
      15:      ch = "@";
      16:      ch = "_";
      default: ch = " ";
    endcase
    return ch[6:0];
  endfunction

  // advance the predicted block by one pixel
  task automatic shade_pixel(input logic [7:0] r, g, b, output logic emit, output shade_t res);
    int w, h, gc, gr, sr, sg, sb, tr, tg, tb;
    int lt, lm, lb, ct, cb, gx, gy, lvl;
    logic end_col, end_row;
    logic [26:0] up;
    logic [7:0] gval, top_px, mid_px;
    emit = 1'b0;
    res = '0;
    w = fit_size(width_reg, MAX_WIDTH);
    h = fit_size(height_reg, HEIGHT_LIMIT);
    gc = int'(col) >> 1;
    gr = int'(row) >> 1;
    end_col = int'(col) >= w - 1;
    end_row = int'(row) >= h - 1;
    if (gc >= LINE_DEPTH) gc = LINE_DEPTH - 1;

    if (!col[0]) begin
      held_px = {r, g, b};
    end else begin
      sr = int'(r) + int'(held_px[23:16]);
      sg = int'(g) + int'(held_px[15:8]);
      sb = int'(b) + int'(held_px[7:0]);
      if (!row[0]) begin
        pair_mem[gc] = {9'(sr), 9'(sg), 9'(sb)};
      end else begin
        up = pair_mem[gc];
        tr = sr + int'(up[26:18]);
        tg = sg + int'(up[17:9]);
        tb = sb + int'(up[8:0]);
        gval = 8'(((((5 * tr) >> 4) + ((9 * tg) >> 4) + (tb >> 3)) >> 2));
        top_px = gray_mem[gc][15:8];
        mid_px = gray_mem[gc][7:0];
        gray_mem[gc] = {mid_px, gval};
        if (gc >= 2 && gr >= 2) begin
          lt = int'(win[47:40]);
          lm = int'(win[39:32]);
          lb = int'(win[31:24]);
          ct = int'(win[23:16]);
          cb = int'(win[7:0]);
          gx = (lt + 2 * lm + lb) - (int'(top_px) + 2 * int'(mid_px) + int'(gval));
          gy = (lt + 2 * ct + int'(top_px)) - (lb + 2 * cb + int'(gval));
          lvl = (((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy)) >> LEVEL_SHIFT;
          lvl = lvl & 31;
          res.level = 5'(lvl);
          res.shade = (lvl <= SHADE_ENTRIES) ? ascii_for(lvl) : CHAR_SPACE;
          res.last  = end_col && end_row;
          emit = 1'b1;
        end
        win = {win[23:0], top_px, mid_px, gval};
      end
    end

    if (end_col) begin
      col = '0;
      row = end_row ? 8'd0 : row + 8'd1;
    end else begin
      col = col + 8'd1;
    end
  endtask

  always @(posedge clk) begin
    shade_t want;
    shade_t next_res;
    logic   emit;
    if (!rst_n) begin
      width_reg  = 9'(SIZE_RESET);
      height_reg = 9'(SIZE_RESET);
      col        = '0;
      row        = '0;
      held_px    = '0;
      win        = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        pair_mem[i] = '0;
        gray_mem[i] = '0;
      end
      shade_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected result level=%0d shade=%0d last=%0d", $time,
                   out_edge_level, out_shade_code, out_last_of_frame);
          errors++;
        end else begin
          want = shade_q.pop_front();
          if (out_edge_level !== want.level) begin
            $display("%0t: edge_level expected %0d, got %0d", $time, want.level,
                     out_edge_level);
            errors++;
          end
          if (out_shade_code !== want.shade) begin
            $display("%0t: shade_code expected %0d, got %0d", $time, want.shade,
                     out_shade_code);
            errors++;
          end
          if (out_last_of_frame !== want.last) begin
            $display("%0t: last_of_frame expected %0d, got %0d", $time, want.last,
                     out_last_of_frame);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        shade_pixel(in_red, in_green, in_blue, emit, next_res);
        if (emit) shade_q.push_back(next_res);
      end
    end
    pending    <= shade_q.size();
    mismatches <= errors;
  end

endmodule

### test/gray_downsample_sobel_ascii_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the gray downsampler with Sobel shading.
module gray_downsample_sobel_ascii_test;
  import gds_pkg::*;

  // no request on any channel for this long means the block hung
  localparam int STALL_LIMIT   = 3000;
  // long sink hold-off that fills the result queue and backs up the input
  localparam int HOLD_CYCLES   = 400;
  // margin after the last result before a register write
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 500;
  localparam int HOLD_AFTER    = 20;

  typedef enum logic [1:0] {PAT_CORNER, PAT_FLAT, PAT_NOISE, PAT_BANDS} pattern_t;
  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} sink_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] out_edge_level;
  logic [6:0] out_shade_code;
  logic       out_last_of_frame;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [8:0] cfg_data;

  int mismatches;
  int pending;
  int idle_cycles  = 0;
  int shades_taken = 0;
  int burst_left   = 0;

  // look of the current picture; redrawn per span unless kept on purpose
  logic [7:0] base_r, base_g, base_b, noise_mask;
  int         step_x, step_y;

  always #4 clk = ~clk;

  gray_downsample_sobel_ascii u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_edge_level    (out_edge_level),
    .out_shade_code    (out_shade_code),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  sobel_shade_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_edge_level    (out_edge_level),
    .out_shade_code    (out_shade_code),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) shades_taken <= shades_taken + 1;
  end

  // Sink: runs of different ready patterns, including stretches that never
  // stall. Once, mid-stream, hold off long enough that the four-entry result
  // queue fills and in_ready has to drop while the source keeps offering.
  initial begin
    int    run_left;
    sink_t mode;
    logic  held_off;
    run_left = 0;
    mode = READY_ALWAYS;
    held_off = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && shades_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (run_left == 0) begin
        mode = sink_t'($urandom_range(0, 3));
        run_left = $urandom_range(8, 80);
      end
      run_left--;
      case (mode)
        READY_ALWAYS: out_ready = 1'b1;
        READY_COIN:   out_ready = $urandom_range(0, 1);
        READY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default:      out_ready = !out_ready;
      endcase
    end
  end

  // Pick a fresh look: noise masks of every width give edge levels from
  // zero up through the mid range, gradients give steady mid levels.
  task automatic redraw();
    base_r = $urandom;
    base_g = $urandom;
    base_b = $urandom;
    noise_mask = 8'((9'h1 << $urandom_range(0, 8)) - 9'h1);
    step_x = $urandom_range(0, 48);
    step_y = $urandom_range(0, 48);
  endtask

  function automatic logic [23:0] paint(input pattern_t pat, input int x, input int y);
    logic [7:0] v;
    case (pat)
      PAT_CORNER: begin
        // gray top-left, middle-left and top-centre bright, the rest dark:
        // the steepest window the gray image allows (level 23)
        v = (((x >> 1) % 3) + ((y >> 1) % 3) <= 1) ? 8'hFF : 8'h00;
        return {v, v, v};
      end
      PAT_FLAT:  return {base_r, base_g, base_b};
      PAT_NOISE: return {base_r ^ (8'($urandom) & noise_mask),
                         base_g ^ (8'($urandom) & noise_mask),
                         base_b ^ (8'($urandom) & noise_mask)};
      default:   return {8'(int'(base_r) + x * step_x + y * step_y),
                         8'(int'(base_g) + x * step_y),
                         8'(int'(base_b) + y * step_x) ^ (8'($urandom) & noise_mask & 8'h0F)};
    endcase
  endfunction

  // Offer one pixel in bursts with random gaps; starts and ends at a falling edge.
  task automatic push_pixel(input logic [23:0] px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    {in_red, in_green, in_blue} = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_span(input int w, input int count, input pattern_t pat, input bit fresh);
    if (fresh) redraw();
    for (int p = 0; p < count; p++) push_pixel(paint(pat, p % w, p / w));
  endtask

  // Drain: stop offering, wait for every expected result, then let the
  // pipeline run dry before touching the registers.
  task automatic settle();
    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Valid stays high across back-to-back writes; drop it after the last one.
  task automatic write_reg(input logic idx, input logic [8:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [8:0] raw_w, input logic [8:0] raw_h);
    settle();
    write_reg(CFG_FRAME_WIDTH, raw_w);
    write_reg(CFG_FRAME_HEIGHT, raw_h);
    cfg_valid = 1'b0;
  endtask

  // Raw register value for an effective size: odd low bit or, at the floor,
  // anything from zero up that clamps to six.
  function automatic logic [8:0] raw_size(input int eff);
    if (eff == SIZE_FLOOR) return 9'($urandom_range(0, 7));
    return 9'(eff | $urandom_range(0, 1));
  endfunction

  initial begin
    int noise_px;
    int ew;
    int eh;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Smallest frame, odd width register: one window at the steepest edge.
    set_frame(9'd7, 9'd6);
    send_span(6, 36, PAT_CORNER, 1'b1);

    // Sizes below the floor clamp to six; all-white frame, flat level zero.
    set_frame(9'd4, 9'd5);
    base_r = 8'hFF;
    base_g = 8'hFF;
    base_b = 8'hFF;
    send_span(6, 36, PAT_FLAT, 1'b0);

    // Width shrinks in mid-frame: stop at row 6, column 13 of a 20-wide
    // frame, drop the width to 8 so the counter wraps on the next pixel,
    // then finish rows 7 to 11 at the new width.
    set_frame(9'd20, 9'd12);
    send_span(20, 133, PAT_NOISE, 1'b1);
    settle();
    write_reg(CFG_FRAME_WIDTH, 9'd8);
    cfg_valid = 1'b0;
    send_span(8, 41, PAT_NOISE, 1'b0);

    // Extremes: an all-ones width saturates to MAX_WIDTH; run the first two
    // rows at that width. Then go to the floor width with an all-ones height
    // and carry on through row 20, and cut the height to the floor in
    // mid-frame so that the frame ends with row 21.
    set_frame(9'h1FF, 9'h000);
    send_span(256, 512, PAT_NOISE, 1'b1);
    set_frame(9'h000, 9'h1FF);
    send_span(6, 114, PAT_BANDS, 1'b1);
    set_frame(9'h000, 9'h000);
    send_span(6, 6, PAT_BANDS, 1'b0);

    // Random frames, mostly small; sometimes keep the sizes and run frames
    // back to back without draining.
    noise_px = 0;
    ew = 0;
    eh = 0;
    while (noise_px < RANDOM_PIXELS) begin
      if (ew == 0 || $urandom_range(0, 3) != 0) begin
        ew = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(13, 20)
                                          : 2 * $urandom_range(3, 12);
        eh = 2 * $urandom_range(3, 7);
        set_frame(raw_size(ew), raw_size(eh));
      end
      send_span(ew, ew * eh, pattern_t'($urandom_range(0, 3)), 1'b1);
      noise_px += ew * eh;
    end

    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
